[hdl/cia_pkg.sv]
// Shared types and operation codes for the constant-folding integer ALU.
// No dependencies.
`default_nettype none
package cia_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned KindW  = 5;
  localparam int unsigned BytesW = 3;

  typedef enum logic [KindW-1:0] {
    KindAdd  = 5'd0,  KindSub  = 5'd1,  KindMul  = 5'd2,  KindDiv  = 5'd3,
    KindMod  = 5'd4,  KindShl  = 5'd5,  KindShr  = 5'd6,  KindAnd  = 5'd7,
    KindXor  = 5'd8,  KindOr   = 5'd9,  KindLt   = 5'd10, KindGt   = 5'd11,
    KindLe   = 5'd12, KindGe   = 5'd13, KindEq   = 5'd14, KindNe   = 5'd15,
    KindLand = 5'd16, KindLor  = 5'd17, KindNeg  = 5'd18, KindNot  = 5'd19,
    KindLnot = 5'd20, KindCast = 5'd21, KindPlus = 5'd22, KindCond = 5'd23
  } kind_e;

  // One pipeline slot: non-divide result rides along with the divider state.
  typedef struct packed {
    logic             valid;
    logic             is_div;
    logic             is_mod;
    logic             neg;
    logic             ok;
    logic [DataW-1:0] simple;
    logic [DataW-1:0] num;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] den;
  } stage_t;

endpackage
`default_nettype wire

[hdl/cia_front.sv]
// Input stage: decodes the request, evaluates all single-cycle operations
// and prepares divider operands. Depends on cia_pkg.
`default_nettype none
module cia_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [cia_pkg::KindW-1:0]          kind_i,
  input  logic [cia_pkg::DataW-1:0]          value_a_i,
  input  logic [cia_pkg::DataW-1:0]          value_b_i,
  input  logic [cia_pkg::DataW-1:0]          value_c_i,
  input  logic                               signed_op_i,
  input  logic [cia_pkg::BytesW-1:0]         cast_bytes_i,
  output cia_pkg::stage_t                    stage_o
);

  localparam logic [cia_pkg::DataW-1:0] SignBit = 32'h8000_0000;

  cia_pkg::stage_t         stage_d, stage_q;
  logic [cia_pkg::DataW-1:0] a, b, ma, mb, ax, bx, r;
  logic [4:0]              sh;
  logic                    lt_ab, lt_ba, ok, is_div, is_mod;

  always_comb begin
    a  = value_a_i;
    b  = value_b_i;
    sh = b[4:0];
    ax = signed_op_i ? (a ^ SignBit) : a;
    bx = signed_op_i ? (b ^ SignBit) : b;
    lt_ab = ax < bx;
    lt_ba = bx < ax;
    ma = (signed_op_i && a[31]) ? (32'd0 - a) : a;
    mb = (signed_op_i && b[31]) ? (32'd0 - b) : b;
    ok = 1'b1;
    is_div = 1'b0;
    is_mod = 1'b0;
    r  = '0;
    case (kind_i)
      cia_pkg::KindAdd:  r = a + b;
      cia_pkg::KindSub:  r = a - b;
      cia_pkg::KindMul:  r = a * b;
      cia_pkg::KindDiv:  is_div = 1'b1;
      cia_pkg::KindMod:  is_mod = 1'b1;
      cia_pkg::KindShl:  r = a << sh;
      cia_pkg::KindShr:  r = signed_op_i ? DataWShr(a, sh) : (a >> sh);
      cia_pkg::KindAnd:  r = a & b;
      cia_pkg::KindXor:  r = a ^ b;
      cia_pkg::KindOr:   r = a | b;
      cia_pkg::KindLt:   r = {31'd0, lt_ab};
      cia_pkg::KindGt:   r = {31'd0, lt_ba};
      cia_pkg::KindLe:   r = {31'd0, !lt_ba};
      cia_pkg::KindGe:   r = {31'd0, !lt_ab};
      cia_pkg::KindEq:   r = {31'd0, a == b};
      cia_pkg::KindNe:   r = {31'd0, a != b};
      cia_pkg::KindLand: r = {31'd0, (a != '0) && (b != '0)};
      cia_pkg::KindLor:  r = {31'd0, (a != '0) || (b != '0)};
      cia_pkg::KindNeg:  r = 32'd0 - a;
      cia_pkg::KindNot:  r = ~a;
      cia_pkg::KindLnot: r = {31'd0, a == '0};
      cia_pkg::KindCast: begin
        case (cast_bytes_i)
          3'd0, 3'd1: r = signed_op_i ? {{24{a[7]}}, a[7:0]} : {24'd0, a[7:0]};
          3'd2:       r = signed_op_i ? {{16{a[15]}}, a[15:0]} : {16'd0, a[15:0]};
          3'd3:       r = signed_op_i ? {{8{a[23]}}, a[23:0]} : {8'd0, a[23:0]};
          default:    r = a;
        endcase
      end
      cia_pkg::KindPlus: r = a;
      cia_pkg::KindCond: r = (a != '0) ? b : value_c_i;
      default:           ok = 1'b0;
    endcase

    stage_d.valid  = valid_i;
    stage_d.is_div = is_div;
    stage_d.is_mod = is_mod;
    stage_d.neg    = signed_op_i && (is_div ? (a[31] ^ b[31]) : a[31]);
    stage_d.ok     = ok && !((is_div || is_mod) && (b == '0));
    stage_d.simple = r;
    stage_d.num    = ma;
    stage_d.rem    = '0;
    stage_d.den    = mb;
  end

  function automatic logic [31:0] DataWShr(input logic [31:0] v, input logic [4:0] s);
    DataWShr = $signed(v) >>> s;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule
`default_nettype wire

[hdl/cia_div_step.sv]
// One restoring-division step: produces one quotient bit per stage.
// Depends on cia_pkg.
`default_nettype none
module cia_div_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  cia_pkg::stage_t stage_i,
  output cia_pkg::stage_t stage_o
);

  cia_pkg::stage_t stage_d, stage_q;
  logic [cia_pkg::DataW:0] trial;
  logic                    take;

  always_comb begin
    stage_d = stage_i;
    // shift next dividend bit into the partial remainder
    trial   = {stage_i.rem, stage_i.num[cia_pkg::DataW-1]};
    take    = trial >= {1'b0, stage_i.den};
    stage_d.rem = take ? 32'(trial - {1'b0, stage_i.den}) : trial[cia_pkg::DataW-1:0];
    stage_d.num = {stage_i.num[cia_pkg::DataW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule
`default_nettype wire

[hdl/c_integer_constant_alu.sv]
// Top level of the C-semantics 32-bit integer ALU.
// Depends on cia_pkg, cia_front and cia_div_step.
`default_nettype none
// One request in, one result out, in order. The block is a fixed pipeline:
// an input register that evaluates every single-cycle operation (including
// the 32x32 multiply), 32 restoring-divider stages that each resolve one
// quotient bit, and an output register that applies sign fix-up. Every
// request passes through every stage whatever the operation, and a new
// request may enter every cycle while the pipe is not held. The whole pipe
// advances together; it holds when a result sits at the output while
// stall_i is high, and then stall_o is raised. Empty slots (bubbles) flow
// through and are not squeezed out. Divide or modulo by zero, and unused
// operation codes, give result 0 with folded low.
module c_integer_constant_alu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic [cia_pkg::KindW-1:0]  kind_i,
  input  logic [cia_pkg::DataW-1:0]  value_a_i,
  input  logic [cia_pkg::DataW-1:0]  value_b_i,
  input  logic [cia_pkg::DataW-1:0]  value_c_i,
  input  logic                       signed_op_i,
  input  logic [cia_pkg::BytesW-1:0] cast_bytes_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic [cia_pkg::DataW-1:0]  result_value_o,
  output logic                       folded_o
);

  localparam int unsigned Steps = cia_pkg::DataW;

  cia_pkg::stage_t           pipe [0:Steps];
  logic                      en;
  logic                      out_valid_q;
  logic [cia_pkg::DataW-1:0] result_d, result_q;
  logic                      folded_d, folded_q;

  // global advance: hold only when a finished result is not taken
  assign en      = !(out_valid_q && stall_i);
  assign stall_o = !en;

  cia_front u_front (
    .clk_i,
    .rst_ni,
    .en_i         (en),
    .valid_i,
    .kind_i,
    .value_a_i,
    .value_b_i,
    .value_c_i,
    .signed_op_i,
    .cast_bytes_i,
    .stage_o      (pipe[0])
  );

  for (genvar g = 0; g < Steps; g++) begin : g_div
    cia_div_step u_step (
      .clk_i,
      .rst_ni,
      .en_i    (en),
      .stage_i (pipe[g]),
      .stage_o (pipe[g+1])
    );
  end

  // sign fix-up; quotient in num, remainder in rem
  always_comb begin
    folded_d = pipe[Steps].ok;
    if (!pipe[Steps].ok) begin
      result_d = '0;
    end else if (pipe[Steps].is_div) begin
      result_d = pipe[Steps].neg ? (32'd0 - pipe[Steps].num) : pipe[Steps].num;
    end else if (pipe[Steps].is_mod) begin
      result_d = pipe[Steps].neg ? (32'd0 - pipe[Steps].rem) : pipe[Steps].rem;
    end else begin
      result_d = pipe[Steps].simple;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= pipe[Steps].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      result_q <= result_d;
      folded_q <= folded_d;
    end
  end

  assign valid_o        = out_valid_q;
  assign result_value_o = result_q;
  assign folded_o       = folded_q;

  a_unfolded_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !folded_q) |-> (result_q == '0))
    else $error("unfolded result is not zero");

  a_stall_rule : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o == (out_valid_q && stall_i))
    else $error("stall_o does not track output occupancy");

  a_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> (out_valid_q == $past(pipe[Steps].valid)))
    else $error("output valid did not follow last divider stage");

endmodule
`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for c_integer_constant_alu: random and directed ALU requests.
// Depends on cia_pkg and the c_integer_constant_alu RTL.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cia_pkg::*;

  // Expected result of one request.
  typedef struct {
    logic [DataW-1:0] value;
    logic             ok;
  } alu_result_t;

  // Golden ALU plus an in-order queue of pending results.
  class alu_scoreboard;
    alu_result_t pending[$];
    int          errors;

    function automatic logic lt(logic [31:0] a, logic [31:0] b, logic sgn);
      if (sgn) return $signed(a) < $signed(b);
      return a < b;
    endfunction

    function automatic alu_result_t compute(logic [4:0] kind, logic [31:0] a, logic [31:0] b,
                                            logic [31:0] c, logic sgn, logic [2:0] nbytes);
      alu_result_t r;
      logic [31:0] ma, mb, q, mask;
      logic [4:0]  sh;
      int          nb;
      r.value = '0;
      r.ok    = 1'b1;
      sh = b[4:0];
      case (kind)
        KindAdd: r.value = a + b;
        KindSub: r.value = a - b;
        KindMul: r.value = a * b;
        KindDiv, KindMod: begin
          if (b == 0) begin
            r.ok = 1'b0;
          end else if (!sgn) begin
            r.value = (kind == KindDiv) ? a / b : a % b;
          end else begin
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            if (kind == KindDiv) begin
              q = ma / mb;
              r.value = (a[31] ^ b[31]) ? -q : q;
            end else begin
              q = ma % mb;
              r.value = a[31] ? -q : q;
            end
          end
        end
        KindShl: r.value = a << sh;
        KindShr: begin
          if (sgn) r.value = $signed(a) >>> sh;
          else     r.value = a >> sh;
        end
        KindAnd: r.value = a & b;
        KindXor: r.value = a ^ b;
        KindOr:  r.value = a | b;
        KindLt:  r.value = {31'd0, lt(a, b, sgn)};
        KindGt:  r.value = {31'd0, lt(b, a, sgn)};
        KindLe:  r.value = {31'd0, !lt(b, a, sgn)};
        KindGe:  r.value = {31'd0, !lt(a, b, sgn)};
        KindEq:  r.value = {31'd0, a == b};
        KindNe:  r.value = {31'd0, a != b};
        KindLand: r.value = {31'd0, (a != 0) && (b != 0)};
        KindLor:  r.value = {31'd0, (a != 0) || (b != 0)};
        KindNeg:  r.value = -a;
        KindNot:  r.value = ~a;
        KindLnot: r.value = {31'd0, a == 0};
        KindCast: begin
          nb = (nbytes == 0) ? 1 : nbytes;
          if (nb >= 4) begin
            r.value = a;
          end else begin
            mask = 32'hffff_ffff >> (8 * (4 - nb));
            r.value = a & mask;
            if (sgn && r.value[8*nb-1]) r.value |= ~mask;
          end
        end
        KindPlus: r.value = a;
        KindCond: r.value = (a != 0) ? b : c;
        default: r.ok = 1'b0;  // unused codes
      endcase
      return r;
    endfunction

    function void note_request(logic [4:0] kind, logic [31:0] a, logic [31:0] b,
                               logic [31:0] c, logic sgn, logic [2:0] nbytes);
      pending.push_back(compute(kind, a, b, c, sgn, nbytes));
    endfunction

    function void check_result(logic [31:0] value, logic ok);
      alu_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%h folded=%b", $time, value, ok);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (value !== e.value) begin
        $display("%0t: result_value expected %h actual %h", $time, e.value, value);
        errors++;
      end
      if (ok !== e.ok) begin
        $display("%0t: folded expected %b actual %b", $time, e.ok, ok);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              valid_i = 1'b0;
  logic              stall_o;
  logic [KindW-1:0]  kind_i = '0;
  logic [DataW-1:0]  value_a_i = '0;
  logic [DataW-1:0]  value_b_i = '0;
  logic [DataW-1:0]  value_c_i = '0;
  logic              signed_op_i = 1'b0;
  logic [BytesW-1:0] cast_bytes_i = '0;
  logic              valid_o;
  logic              stall_i = 1'b0;
  logic [DataW-1:0]  result_value_o;
  logic              folded_o;

  // Idle percentages per phase: sender gaps and receiver stalls.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  alu_scoreboard sb = new();

  c_integer_constant_alu uut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Result side: random stall, check each accepted result.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) sb.check_result(result_value_o, folded_o);
    stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Send one request and hold it until accepted.
  task automatic send_request(logic [4:0] kind, logic [31:0] a, logic [31:0] b,
                              logic [31:0] c, logic sgn, logic [2:0] nbytes);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i      <= 1'b1;
    kind_i       <= kind;
    value_a_i    <= a;
    value_b_i    <= b;
    value_c_i    <= c;
    signed_op_i  <= sgn;
    cast_bytes_i <= nbytes;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    sb.note_request(kind, a, b, c, sgn, nbytes);
  endtask

  // Operands biased toward corners so compares, overflow and shifts get hit.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return $urandom_range(16);
      5: return -$urandom_range(16);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    logic [31:0] a, b;
    a = pick_operand();
    b = ($urandom_range(3) == 0) ? a : pick_operand();
    send_request(5'($urandom_range(31)), a, b, pick_operand(), 1'($urandom_range(1)),
                 3'($urandom_range(7)));
  endtask

  initial begin
    int waited;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: zero divisor, min / -1, shift mask, arithmetic shift, casts.
    send_request(KindDiv, 32'd7, 32'd0, 0, 1'b0, 3'd4);
    send_request(KindMod, 32'd7, 32'd0, 0, 1'b1, 3'd4);
    send_request(KindDiv, 32'h8000_0000, 32'hffff_ffff, 0, 1'b1, 3'd4);
    send_request(KindMod, 32'h8000_0000, 32'hffff_ffff, 0, 1'b1, 3'd4);
    send_request(KindDiv, 32'hffff_fff9, 32'd2, 0, 1'b0, 3'd4);
    send_request(KindMod, 32'hffff_fff9, 32'd2, 0, 1'b1, 3'd4);
    send_request(KindShl, 32'h1, 32'd33, 0, 1'b0, 3'd4);
    send_request(KindShr, 32'h8000_0000, 32'd31, 0, 1'b1, 3'd4);
    send_request(KindShr, 32'h8000_0000, 32'd0, 0, 1'b1, 3'd4);
    send_request(KindShr, 32'h8000_0000, 32'd4, 0, 1'b0, 3'd4);
    send_request(KindLt, 32'hffff_ffff, 32'd1, 0, 1'b1, 3'd4);
    send_request(KindLt, 32'hffff_ffff, 32'd1, 0, 1'b0, 3'd4);
    send_request(KindCast, 32'h0000_0080, 0, 0, 1'b1, 3'd0);
    send_request(KindCast, 32'h0000_8000, 0, 0, 1'b1, 3'd2);
    send_request(KindCast, 32'h0080_0000, 0, 0, 1'b1, 3'd3);
    send_request(KindCast, 32'h8765_4321, 0, 0, 1'b1, 3'd7);
    send_request(KindCast, 32'h0000_00ff, 0, 0, 1'b0, 3'd1);
    send_request(KindCond, 32'd0, 32'hdead_beef, 32'h1234_5678, 1'b0, 3'd4);
    send_request(KindCond, 32'd5, 32'hdead_beef, 32'h1234_5678, 1'b0, 3'd4);
    send_request(KindMul, 32'hffff_ffff, 32'hffff_ffff, 0, 1'b0, 3'd4);
    send_request(KindNeg, 32'h8000_0000, 0, 0, 1'b0, 3'd4);
    send_request(5'd31, 32'd1, 32'd1, 32'd1, 1'b1, 3'd4);
    send_request(KindLnot, 32'd0, 0, 0, 1'b0, 3'd4);

    // Four idling phases: none, sender, receiver, both.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 57 : (phase == 3) ? 38 : 0;
      recv_stall_pct = (phase == 2) ? 57 : (phase == 3) ? 38 : 0;
      repeat (460) send_random();
    end
    valid_i <= 1'b0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("tb: errors");
    $finish;
  end
endmodule
`default_nettype wire
